@@ hdl/bmf_pkg.sv @@
// Shared constants and types for the 3x3 box mean filter.
// No dependencies; every other file of the block but bmf_ram uses this package.
package bmf_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned COL_OUT_W     = 11;
  localparam int unsigned CFG_W         = 12;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned MAX_WIDTH_DEF = 2048;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [CFG_W-1:0] MIN_DIM    = 12'd3;

  // Nine 8-bit pixels sum to at most 2295.
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 16;
  // ceil(2^16 / 9); exact floor division for every sum below 2296.
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Position information of one accepted pixel.
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
  } scan_t;

endpackage

@@ hdl/bmf_pix_if.sv @@
// Pixel input channel: valid/ready handshake with one 8-bit pixel per beat.
// Depends on bmf_pkg.
interface bmf_pix_if;
  import bmf_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source(output valid, output pixel_value, input ready);
  modport sink(input valid, input pixel_value, output ready);
endinterface

@@ hdl/bmf_res_if.sv @@
// Result channel: valid/ready handshake carrying one filtered pixel per beat.
// Depends on bmf_pkg.
interface bmf_res_if;
  import bmf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     mean_value;
  logic [ROW_W-1:0]     center_row;
  logic [COL_OUT_W-1:0] center_col;
  logic                 frame_last;

  modport source(output valid, output mean_value, output center_row,
                 output center_col, output frame_last, input ready);
  modport sink(input valid, input mean_value, input center_row,
               input center_col, input frame_last, output ready);
endinterface

@@ hdl/bmf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bmf_scan.sv @@
// Size registers and raster position counters of the box mean filter.
// Depends on bmf_pkg.
module bmf_scan #(
  parameter int unsigned MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmf_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            advance,
  output logic [$clog2(MAX_WIDTH)-1:0]    col,
  output bmf_pkg::scan_t                  info
);
  import bmf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [WW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [CW-1:0]    c;
  logic [ROW_W-1:0] r;
  logic             last_col;
  logic             last_row;

  always_comb begin
    if (width_r < MIN_DIM) begin
      eff_w = WW'(MIN_DIM);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    eff_h = (height_r < MIN_DIM) ? ROW_W'(MIN_DIM) : ROW_W'(height_r);

    // A counter left beyond a shrunken size counts as the last position.
    c = (WW'(col_cnt_r) >= eff_w) ? CW'(eff_w - WW'(1)) : col_cnt_r;
    r = (row_cnt_r >= eff_h) ? eff_h - ROW_W'(1) : row_cnt_r;

    last_col = (WW'(c) == eff_w - WW'(1));
    last_row = (r == eff_h - ROW_W'(1));

    info.emit = (r >= ROW_W'(2)) && (c >= CW'(2));
    info.last = last_row && last_col;
    info.row  = r;
    col       = c;

    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (advance) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : r + ROW_W'(1);
      end else begin
        col_cnt_nxt = c + CW'(1);
        row_cnt_nxt = r;
      end
    end

    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_nxt  = cfg_wdata;
        REG_IMAGE_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

@@ hdl/bmf_mean.sv @@
// Window, neighborhood sum, divide-by-nine and result register of the filter.
// Depends on bmf_pkg and bmf_res_if; works on data read from the line store RAM.
module bmf_mean #(
  parameter int unsigned MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [$clog2(MAX_WIDTH)-1:0]   col,
  input  bmf_pkg::scan_t                 info,
  input  logic [bmf_pkg::PIX_W-1:0]      pix,
  input  logic [2*bmf_pkg::PIX_W-1:0]    ram_rdata,
  output logic                           in_ready,
  output logic                           ram_we,
  output logic [$clog2(MAX_WIDTH)-1:0]   ram_waddr,
  output logic [2*bmf_pkg::PIX_W-1:0]    ram_wdata,
  bmf_res_if.source                      res
);
  import bmf_pkg::*;

  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  // Stage 1: line store data arrives from the RAM.
  logic             s1_v_r, s1_v_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  scan_t            s1_info_r;
  // Stage 2: registered neighborhood sum.
  logic                 s2_v_r, s2_v_nxt;
  logic [SUM_W-1:0]     s2_sum_r;
  logic [ROW_W-1:0]     s2_row_r;
  logic [COL_OUT_W-1:0] s2_col_r;
  logic                 s2_last_r;
  // Stage 3: result register.
  logic                 s3_v_r, s3_v_nxt;
  logic [PIX_W-1:0]     s3_mean_r;
  logic [ROW_W-1:0]     s3_row_r;
  logic [COL_OUT_W-1:0] s3_col_r;
  logic                 s3_last_r;

  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] top_pix;
  logic [PIX_W-1:0] mid_pix;
  logic [SUM_W-1:0] sum;
  logic [PROD_W-1:0] prod;
  logic en1, en2, en3;
  logic s1_fire;

  assign en3      = !s3_v_r || res.ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;
  assign s1_fire  = s1_v_r && en2;

  // Upper byte holds the row two above, lower byte the row just above.
  assign top_pix = ram_rdata[2*PIX_W-1:PIX_W];
  assign mid_pix = ram_rdata[PIX_W-1:0];

  assign ram_we    = s1_fire;
  assign ram_waddr = s1_col_r;
  assign ram_wdata = {mid_pix, s1_pix_r};

  assign sum = SUM_W'(win_r[0]) + SUM_W'(win_r[1]) + SUM_W'(win_r[2])
             + SUM_W'(win_r[3]) + SUM_W'(win_r[4]) + SUM_W'(win_r[5])
             + SUM_W'(top_pix) + SUM_W'(mid_pix) + SUM_W'(s1_pix_r);

  assign prod = PROD_W'(s2_sum_r) * PROD_W'(DIV9_RECIP);

  always_comb begin
    s1_v_nxt = en1 ? accept : s1_v_r;
    s2_v_nxt = en2 ? (s1_fire && s1_info_r.emit) : s2_v_r;
    s3_v_nxt = en3 ? s2_v_r : s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
      if (s1_fire) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top_pix;
        win_r[4] <= mid_pix;
        win_r[5] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= pix;
      s1_col_r  <= col;
      s1_info_r <= info;
    end
    if (s1_fire) begin
      s2_sum_r  <= sum;
      s2_row_r  <= s1_info_r.row - ROW_W'(1);
      s2_col_r  <= COL_OUT_W'(s1_col_r - CW'(1));
      s2_last_r <= s1_info_r.last;
    end
    if (en3 && s2_v_r) begin
      s3_mean_r <= prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
      s3_last_r <= s2_last_r;
    end
  end

  assign res.valid      = s3_v_r;
  assign res.mean_value = s3_mean_r;
  assign res.center_row = s3_row_r;
  assign res.center_col = s3_col_r;
  assign res.frame_last = s3_last_r;

endmodule

@@ hdl/box_mean_filter_3x3_core.sv @@
// 3x3 box mean filter. Pixels enter in raster order at one pixel per clock and
// every interior position leaves floor(sum of its nine neighbors / 9) with its
// center row and column; each result passes stages 1 and 2 and is offered from
// the stage 3 register. Border positions give no result. The input stalls only
// while a result waits at the output with all three pipeline stages full. The
// two previous rows live in one line store RAM, read at the column of the
// accepted pixel and written back when that pixel moves on, normally the next
// cycle; consecutive pixels never share a column, so no forwarding is needed.
// The size registers may only be written while no pixel is in flight. The
// line store needs no clearing pass: the block takes pixels right after reset.
// Depends on bmf_pkg, bmf_pix_if, bmf_res_if, bmf_ram, bmf_scan and bmf_mean.
module box_mean_filter_3x3_core #(
  parameter int unsigned MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmf_pkg::CFG_W-1:0]     cfg_wdata,
  bmf_pix_if.sink                       in_pix,
  bmf_res_if.source                     out_res
);
  import bmf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic                 accept;
  logic                 in_ready;
  logic [CW-1:0]        col;
  scan_t                info;
  logic                 ram_we;
  logic [CW-1:0]        ram_waddr;
  logic [2*PIX_W-1:0]   ram_wdata;
  logic [2*PIX_W-1:0]   ram_rdata;

  assign in_pix.ready = in_ready;
  assign accept       = in_pix.valid && in_ready;

  bmf_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (accept),
    .col       (col),
    .info      (info)
  );

  bmf_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (ram_rdata)
  );

  bmf_mean #(.MAX_WIDTH(MAX_WIDTH)) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .col       (col),
    .info      (info),
    .pix       (in_pix.pixel_value),
    .ram_rdata (ram_rdata),
    .in_ready  (in_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .res       (out_res)
  );

`ifndef SYNTHESIS
  // The write-back of one pixel must never hit the column read for the next.
  a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && accept |-> ram_waddr != col)
    else $error("line store read and write at the same column");

  // With the result register empty the whole pipeline must be open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_res.valid |-> in_pix.ready)
    else $error("input stalled although no result is waiting");

  // A line store read is written back the next cycle unless the output stalls.
  a_writeback_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ram_we || (out_res.valid && !out_res.ready))
    else $error("line store write-back missing after a read");
`endif

endmodule
